// ===== rtl/kcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcd_pkg: shared types and constants of the key click detector
// Action and request codes, register indexes, reset values of the settings,
// and the packed records for settings, detector state and input words.
// ----------------------------------------------------------------------------
package kcd_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    ActNone   = 2'd0,
    ActClick  = 2'd1,
    ActDouble = 2'd2,
    ActLong   = 2'd3
  } kcd_action_e;

  typedef enum logic {
    ReqTick = 1'b0,
    ReqRead = 1'b1
  } kcd_req_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegDebounceMs     = 3'd0,
    RegPollInterval   = 3'd1,
    RegClickMinMs     = 3'd2,
    RegLongPressMs    = 3'd3,
    RegClickConfirmMs = 3'd4,
    RegUnreadTimeout  = 3'd5,
    RegActiveLevel    = 3'd6
  } kcd_reg_e;

  localparam logic [7:0]  RstDebounceMs     = 8'd5;
  localparam logic [7:0]  RstPollInterval   = 8'd5;
  localparam logic [15:0] RstClickMinMs     = 16'd30;
  localparam logic [15:0] RstLongPressMs    = 16'd2000;
  localparam logic [15:0] RstClickConfirmMs = 16'd500;
  localparam logic [15:0] RstUnreadTimeout  = 16'd1000;
  localparam logic        RstActiveLevel    = 1'b1;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [7:0]  poll_interval;
    logic [15:0] click_min_ms;
    logic [15:0] long_press_ms;
    logic [15:0] click_confirm_ms;
    logic [15:0] unread_timeout_ms;
    logic        active_level;
  } kcd_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] last_poll_ms;
    logic [TimeW-1:0] debounce_stamp;
    logic [TimeW-1:0] press_stamp;
    logic [TimeW-1:0] unread_stamp;
    logic             debounced_pressed;
    logic             key_down;
    logic             click_confirmed;
    kcd_action_e      pending_action;
  } kcd_state_t;

  typedef struct packed {
    kcd_req_e req_type;
    logic     pin_level;
  } kcd_item_t;

endpackage : kcd_pkg
`default_nettype wire

// ===== rtl/kcd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcd_if: handshake channels of the key click detector
// Request channel, result channel and settings write channel, each with
// valid, ready and its payload.
// ----------------------------------------------------------------------------
interface kcd_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic pin_level;

  modport source (output valid, output req_type, output pin_level, input ready);
  modport sink   (input valid, input req_type, input pin_level, output ready);
endinterface : kcd_in_if

interface kcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       pressed;

  modport source (output valid, output action, output pressed, input ready);
  modport sink   (input valid, input action, input pressed, output ready);
endinterface : kcd_out_if

interface kcd_cfg_if;
  import kcd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : kcd_cfg_if
`default_nettype wire

// ===== rtl/key_click_double_long_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_click_double_long_detector: click, double click and long press detector
// Debounces a key pin sampled once per millisecond tick and reports clicks,
// double clicks and long presses to a reader.
// ----------------------------------------------------------------------------
// Every input word is either a one-millisecond tick that carries the raw pin
// level or a read request, and every input word produces exactly one result
// word holding the action (nonzero only for reads) and the debounced key
// level. The block accepts one word per clock cycle for as long as the
// result side keeps up; a word is captured in an input register, its whole
// effect on the detector state is formed by the next-state logic, and the
// result is held in an output register. The deepest path is the 32-bit
// millisecond increment followed by the modular subtractions and compares
// of the poll, debounce, hold-time and unread-timeout checks. Settings are
// written through the configuration channel, which is always ready; they
// must be changed only while no word is in flight. Register indexes beyond
// the last register are ignored.
// ----------------------------------------------------------------------------
module key_click_double_long_detector (
  input  wire    clk_i,
  input  wire    rst_ni,
  kcd_in_if.sink   in_i,
  kcd_out_if.source out_o,
  kcd_cfg_if.sink  cfg_i
);
  import kcd_pkg::*;

  kcd_cfg_t    cfg_q, cfg_d;
  kcd_state_t  state_q, state_d;
  logic        s1_valid_q;
  kcd_item_t   s1_item_q;
  logic        out_valid_q;
  kcd_action_e out_action_q;
  logic        out_pressed_q;
  kcd_action_e core_action;
  logic        advance;
  logic        in_fire;

  // The result register frees up when it is empty or being taken; the input
  // register moves forward whenever the result register can take it.
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  // Settings decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegDebounceMs:     cfg_d.debounce_ms       = cfg_i.data[7:0];
        RegPollInterval:   cfg_d.poll_interval     = cfg_i.data[7:0];
        RegClickMinMs:     cfg_d.click_min_ms      = cfg_i.data;
        RegLongPressMs:    cfg_d.long_press_ms     = cfg_i.data;
        RegClickConfirmMs: cfg_d.click_confirm_ms  = cfg_i.data;
        RegUnreadTimeout:  cfg_d.unread_timeout_ms = cfg_i.data;
        RegActiveLevel:    cfg_d.active_level      = cfg_i.data[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms       <= RstDebounceMs;
      cfg_q.poll_interval     <= RstPollInterval;
      cfg_q.click_min_ms      <= RstClickMinMs;
      cfg_q.long_press_ms     <= RstLongPressMs;
      cfg_q.click_confirm_ms  <= RstClickConfirmMs;
      cfg_q.unread_timeout_ms <= RstUnreadTimeout;
      cfg_q.active_level      <= RstActiveLevel;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= '{req_type: kcd_req_e'(in_i.req_type), pin_level: in_i.pin_level};
    end
  end

  kcd_core u_core (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .state_o  (state_d),
    .action_o (core_action)
  );

  // Detector state is updated exactly once per word, as the word moves into
  // the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{default: '0, pending_action: ActNone};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_action_q  <= core_action;
      out_pressed_q <= state_d.debounced_pressed;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.action  = out_action_q;
  assign out_o.pressed = out_pressed_q;

`ifndef SYNTHESIS
  // A double click or long press is only recorded once the key is released
  // from the judge's point of view.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.pending_action == ActDouble || state_q.pending_action == ActLong)
      |-> !state_q.key_down)
    else $error("key_down set while a double click or long press is pending");

  // Confirmation only exists for a pending single click.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.click_confirmed |-> (state_q.pending_action == ActClick))
    else $error("click confirmed without a pending click");

  // Ticks never report an action.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (s1_item_q.req_type == ReqTick)) |=> (out_action_q == ActNone))
    else $error("tick produced a nonzero action");

  // A word in the result register that is not taken stays there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_action_q)
      && $stable(out_pressed_q)))
    else $error("stalled result changed");
`endif

endmodule : key_click_double_long_detector
`default_nettype wire

// ===== rtl/kcd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcd_core: next-state logic of the key click detector
// Given the current detector state, the settings and one request word, it
// forms the state after that word and the action that a read returns.
// ----------------------------------------------------------------------------
module kcd_core (
  input  kcd_pkg::kcd_cfg_t    cfg_i,
  input  kcd_pkg::kcd_state_t  state_i,
  input  kcd_pkg::kcd_item_t   item_i,
  output kcd_pkg::kcd_state_t  state_o,
  output kcd_pkg::kcd_action_e action_o
);
  import kcd_pkg::*;

  kcd_state_t       st;
  kcd_action_e      act;
  logic             raw_pressed;
  logic [TimeW-1:0] now_next;
  logic [TimeW-1:0] held;
  logic             debounce_ok;
  logic             smp_pressed;
  logic [TimeW-1:0] smp_stamp;
  logic             first;
  logic             second;

  always_comb begin
    st          = state_i;
    act         = ActNone;
    raw_pressed = (item_i.pin_level == cfg_i.active_level);
    now_next    = state_i.now_ms + TimeW'(1);
    held        = now_next - state_i.press_stamp;
    debounce_ok = (now_next - state_i.debounce_stamp) >= TimeW'(cfg_i.debounce_ms);

    // Debounced sample, taken into the state only when the judge runs.
    smp_pressed = state_i.debounced_pressed;
    smp_stamp   = state_i.debounce_stamp;
    if (raw_pressed != state_i.debounced_pressed) begin
      if (debounce_ok) begin
        smp_stamp   = now_next;
        smp_pressed = raw_pressed;
      end
    end else begin
      smp_stamp = now_next;
    end

    first  = (state_i.pending_action == ActNone);
    second = (state_i.pending_action == ActClick) && !state_i.click_confirmed;

    if (item_i.req_type == ReqTick) begin
      st.now_ms = now_next;
      if ((now_next - state_i.last_poll_ms) > TimeW'(cfg_i.poll_interval)) begin
        st.last_poll_ms = now_next;
        if (first || second) begin
          st.debounce_stamp    = smp_stamp;
          st.debounced_pressed = smp_pressed;
          if (!state_i.key_down) begin
            if (smp_pressed) begin
              st.key_down    = 1'b1;
              st.press_stamp = now_next;
            end else if (second && (held >= TimeW'(cfg_i.click_confirm_ms))) begin
              st.click_confirmed = 1'b1;
            end
          end else begin
            if (!smp_pressed) begin
              st.key_down = 1'b0;
              if (held >= TimeW'(cfg_i.click_min_ms)) begin
                st.pending_action = first ? ActClick : ActDouble;
              end
            end else if (held >= TimeW'(cfg_i.long_press_ms)) begin
              st.key_down       = 1'b0;
              st.pending_action = ActLong;
            end
          end
        end
        // Unread timeout runs on every poll, after the judge.
        if (st.pending_action == ActNone) begin
          st.unread_stamp = now_next;
        end else if ((now_next - state_i.unread_stamp) >
                     TimeW'(cfg_i.unread_timeout_ms)) begin
          st.click_confirmed = 1'b0;
          st.pending_action  = ActNone;
        end
      end
    end else begin
      if (state_i.pending_action == ActClick) begin
        if (state_i.click_confirmed) begin
          act                = ActClick;
          st.click_confirmed = 1'b0;
          st.pending_action  = ActNone;
        end
      end else begin
        act                = state_i.pending_action;
        st.click_confirmed = 1'b0;
        st.pending_action  = ActNone;
      end
    end
  end

  assign state_o  = st;
  assign action_o = act;

endmodule : kcd_core
`default_nettype wire

// ===== test/key_click_double_long_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_click_double_long_detector_tb: self-checking bench of the key detector
// Feeds millisecond ticks and reads under several settings, predicts every
// result word in a scoreboard and compares it field by field with the block.
// ----------------------------------------------------------------------------
module key_click_double_long_detector_tb;
  import kcd_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned HoldOffLen   = 100;
  localparam int unsigned SettleCycles = 8;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    kcd_action_e action;
    logic        pressed;
  } key_result_t;

  typedef enum logic [1:0] {
    RdyAlways,
    RdyCoin,
    RdyOneInFour,
    RdyRareStall
  } ready_mode_e;

  // --------------------------------------------------------------------------
  // Scoreboard. It keeps its own copy of the settings and of the detector
  // state, predicts the result word of every accepted input word, and checks
  // the result words in order against those predictions.
  // --------------------------------------------------------------------------
  class key_action_scoreboard;
    kcd_cfg_t    cfg;
    logic [31:0] now_ms, last_poll_ms, settle_stamp, press_stamp, unread_stamp;
    bit          level_pressed, key_held, click_ok;
    kcd_action_e pending;
    key_result_t expected_words[$];
    int          errors, reads, clicks, doubles, longs;

    function new();
      cfg.debounce_ms       = RstDebounceMs;
      cfg.poll_interval     = RstPollInterval;
      cfg.click_min_ms      = RstClickMinMs;
      cfg.long_press_ms     = RstLongPressMs;
      cfg.click_confirm_ms  = RstClickConfirmMs;
      cfg.unread_timeout_ms = RstUnreadTimeout;
      cfg.active_level      = RstActiveLevel;
      now_ms        = '0;
      last_poll_ms  = '0;
      settle_stamp  = '0;
      press_stamp   = '0;
      unread_stamp  = '0;
      level_pressed = 1'b0;
      key_held      = 1'b0;
      click_ok      = 1'b0;
      pending       = ActNone;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (kcd_reg_e'(idx))
        RegDebounceMs:     cfg.debounce_ms       = value[7:0];
        RegPollInterval:   cfg.poll_interval     = value[7:0];
        RegClickMinMs:     cfg.click_min_ms      = value;
        RegLongPressMs:    cfg.long_press_ms     = value;
        RegClickConfirmMs: cfg.click_confirm_ms  = value;
        RegUnreadTimeout:  cfg.unread_timeout_ms = value;
        RegActiveLevel:    cfg.active_level      = value[0];
        default: ;
      endcase
    endfunction

    // A changed level is taken over once it has been seen for debounce_ms;
    // a level equal to the accepted one restarts the settle time.
    function bit debounce_pin(bit pin);
      bit          raw;
      logic [31:0] since;
      raw   = (pin == cfg.active_level);
      since = now_ms - settle_stamp;
      if (raw != level_pressed) begin
        if (since >= {24'd0, cfg.debounce_ms}) begin
          settle_stamp  = now_ms;
          level_pressed = raw;
        end
      end else begin
        settle_stamp = now_ms;
      end
      return level_pressed;
    endfunction

    function void classify_press(bit pin);
      bit          first, second;
      logic [31:0] held;
      first  = (pending == ActNone);
      second = (pending == ActClick) && !click_ok;
      if (!first && !second) return;
      if (!key_held) begin
        if (debounce_pin(pin)) begin
          key_held    = 1'b1;
          press_stamp = now_ms;
        end else if (second && (now_ms - press_stamp) >= {16'd0, cfg.click_confirm_ms}) begin
          click_ok = 1'b1;
        end
      end else begin
        held = now_ms - press_stamp;
        if (!debounce_pin(pin)) begin
          key_held = 1'b0;
          if (held >= {16'd0, cfg.click_min_ms}) pending = first ? ActClick : ActDouble;
        end else if (held >= {16'd0, cfg.long_press_ms}) begin
          key_held = 1'b0;
          pending  = ActLong;
        end
      end
    endfunction

    function void note_word(kcd_req_e req, bit pin);
      key_result_t res;
      res.action = ActNone;
      if (req == ReqTick) begin
        now_ms = now_ms + 32'd1;
        if ((now_ms - last_poll_ms) > {24'd0, cfg.poll_interval}) begin
          last_poll_ms = now_ms;
          classify_press(pin);
          if (pending == ActNone) begin
            unread_stamp = last_poll_ms;
          end else if ((last_poll_ms - unread_stamp) > {16'd0, cfg.unread_timeout_ms}) begin
            click_ok = 1'b0;
            pending  = ActNone;
          end
        end
      end else begin
        reads++;
        // An unconfirmed click stays pending and reads as nothing.
        if (pending != ActClick || click_ok) begin
          res.action = pending;
          click_ok   = 1'b0;
          pending    = ActNone;
        end
      end
      res.pressed = level_pressed;
      case (res.action)
        ActClick:  clicks++;
        ActDouble: doubles++;
        ActLong:   longs++;
        default: ;
      endcase
      expected_words.push_back(res);
    endfunction

    function void check_word(logic [1:0] action, logic pressed);
      key_result_t want;
      if (expected_words.size() == 0) begin
        flag($sformatf("result word with nothing pending: action %0d pressed %0b",
                       action, pressed));
        return;
      end
      want = expected_words.pop_front();
      if (action !== want.action || pressed !== want.pressed)
        flag($sformatf("result mismatch: action exp %0d got %0d, pressed exp %0b got %0b",
                       want.action, action, want.pressed, pressed));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  kcd_in_if  in_if ();
  kcd_out_if out_if ();
  kcd_cfg_if cfg_if ();

  key_click_double_long_detector i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  key_action_scoreboard sb = new();

  int unsigned cycles;
  int          words_sent;
  int          burst_left;
  bit          no_gaps;
  int          hold_off_left;
  int          pattern_left;
  int unsigned pattern_step;
  ready_mode_e pattern_mode;

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles with %0d words outstanding", cycles,
               sb.outstanding());
      $display("key_click_double_long_detector verification failed");
      $finish;
    end
  end

  // Result side. A long hold-off, when one is requested, takes priority over
  // the regular pattern; otherwise the pattern switches at random between
  // always ready, coin flips, one in four and rare single stalls.
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_if.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_mode = ready_mode_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(8, 48);
      end
      pattern_left--;
      pattern_step++;
      case (pattern_mode)
        RdyAlways:    out_if.ready <= 1'b1;
        RdyCoin:      out_if.ready <= 1'($urandom_range(0, 1));
        RdyOneInFour: out_if.ready <= (pattern_step % 4 == 0);
        default:      out_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Every word the block hands over is checked at the edge that moves it.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_word(out_if.action, out_if.pressed);
  end

  // --------------------------------------------------------------------------
  // Drivers. Everything changes at the falling edge; handshakes are judged at
  // the rising edge. The request valid is left high after a word so that a
  // following word in the same burst goes out without a bubble.
  // --------------------------------------------------------------------------
  task automatic send_word(kcd_req_e req, bit pin);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.req_type  <= req;
    in_if.pin_level <= pin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_word(req, pin);
    words_sent++;
  endtask

  task automatic ticks(int n, bit pin);
    repeat (n) send_word(ReqTick, pin);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_settings(logic [15:0] deb, logic [15:0] poll, logic [15:0] min_ms,
                                logic [15:0] long_ms, logic [15:0] confirm,
                                logic [15:0] unread, logic [15:0] level);
    write_reg(RegDebounceMs, deb);
    write_reg(RegPollInterval, poll);
    write_reg(RegClickMinMs, min_ms);
    write_reg(RegLongPressMs, long_ms);
    write_reg(RegClickConfirmMs, confirm);
    write_reg(RegUnreadTimeout, unread);
    write_reg(RegActiveLevel, level);
  endtask

  // Drops valid and waits until every predicted word has come back, then
  // lets the two-stage pipeline settle before anything else happens.
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly whole presses: the key is held for a random time and released for
  // a random time, with reads dropped in between and the odd bounce on the
  // pin. Now and then a stretch of pure pin noise or a run of reads.
  task automatic press_sequences(int n_words, int max_hold);
    int stop_at;
    int hold;
    int rest;
    bit act;
    bit noisy;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      act   = sb.cfg.active_level;
      noisy = ($urandom_range(0, 3) == 0);
      hold  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(1, max_hold);
      rest  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(1, max_hold);
      case ($urandom_range(0, 9))
        8: repeat ($urandom_range(1, 8)) send_word(ReqTick, 1'($urandom_range(0, 1)));
        9: repeat ($urandom_range(1, 3)) send_word(ReqRead, 1'($urandom_range(0, 1)));
        default: begin
          for (int i = 0; i < hold + rest; i++) begin
            if ($urandom_range(0, 5) == 0) send_word(ReqRead, 1'($urandom_range(0, 1)));
            send_word(ReqTick, ((i < hold) ? act : !act) ^ (noisy && $urandom_range(0, 7) == 0));
          end
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.req_type  = ReqTick;
    in_if.pin_level = 1'b0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = RegDebounceMs;
    cfg_if.data     = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // A few words under the reset settings; with a slow poll nothing settles.
    send_word(ReqTick, 1'b1);
    send_word(ReqRead, 1'b0);
    send_word(ReqTick, 1'b0);
    send_word(ReqRead, 1'b1);
    wait_drained();

    // Directed part with a judge run on every tick and no debounce delay.
    // A write to the unused index must leave every setting alone.
    apply_settings(16'd0, 16'd0, 16'd2, 16'd5, 16'd4, 16'd6, 16'd1);
    write_reg(RegUnused, 16'hFFFF);
    // A single click, read once before it is confirmed and once after.
    ticks(3, 1'b1);
    ticks(1, 1'b0);
    send_word(ReqRead, 1'b0);
    ticks(2, 1'b0);
    send_word(ReqRead, 1'b1);
    // A long press; the key stays down after the read and counts as a new
    // press, which is released into a click and followed by a second press.
    ticks(6, 1'b1);
    send_word(ReqRead, 1'b0);
    ticks(2, 1'b1);
    ticks(1, 1'b0);
    ticks(3, 1'b1);
    ticks(1, 1'b0);
    // Whatever is pending now ages past the unread timeout before the read.
    ticks(7, 1'b0);
    send_word(ReqRead, 1'b0);
    wait_drained();

    // Fast settings with clicks and doubles in reach. Halfway through the
    // result side holds off for a long stretch while words keep coming, and
    // afterwards the sender pauses until every result is back.
    apply_settings(16'd1, 16'd0, 16'd3, 16'd10, 16'd6, 16'd25, 16'd1);
    press_sequences(60, 12);
    hold_off_left = HoldOffLen;
    no_gaps       = 1'b1;
    press_sequences(30, 12);
    no_gaps = 1'b0;
    wait_drained();
    press_sequences(40, 12);
    wait_drained();

    // Every setting at zero and an active-low key.
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    press_sequences(40, 4);
    wait_drained();

    // Every setting at its top value, written with all data bits set.
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    press_sequences(40, 20);
    wait_drained();

    // Active-low key with debounce and a poll every other tick.
    apply_settings(16'd2, 16'd1, 16'd4, 16'd14, 16'd8, 16'd30, 16'd0);
    press_sequences(110, 16);
    wait_drained();

    // Slower polling than debounce, short confirm and timeout.
    apply_settings(16'd0, 16'd2, 16'd1, 16'd8, 16'd3, 16'd12, 16'd1);
    press_sequences(60, 10);
    wait_drained();

    if (sb.outstanding() != 0)
      sb.flag($sformatf("%0d result words never arrived", sb.outstanding()));

    $display("Sent %0d words (%0d reads) over seven settings, including all-zero and all-ones.",
             words_sent, sb.reads);
    $display("Reads returned %0d clicks, %0d double clicks and %0d long presses; %0d errors.",
             sb.clicks, sb.doubles, sb.longs, sb.errors);
    if (sb.errors == 0) begin
      $display("key_click_double_long_detector verification clean");
    end else begin
      $display("key_click_double_long_detector verification failed");
    end
    $finish;
  end

endmodule : key_click_double_long_detector_tb
